### rtl/stc_pkg.sv
// Shared types and codes for the 8-bit teaching CPU.
// Beat structs, command and opcode codes, memory and register port bundles.
// No dependencies.
package stc_pkg;

    localparam int MEM_BYTES = 256;
    localparam int NUM_REGS  = 16;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] addr;
        logic [3:0] reg_index;
        logic [7:0] data;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  pc_now;
        logic [1:0]  run_status;
        logic [15:0] last_instruction;
    } rsp_beat_t;

    localparam logic [2:0] OP_STEP  = 3'd0;
    localparam logic [2:0] OP_WMEM  = 3'd1;
    localparam logic [2:0] OP_RMEM  = 3'd2;
    localparam logic [2:0] OP_RESET = 3'd3;
    localparam logic [2:0] OP_RREG  = 3'd4;
    localparam logic [2:0] OP_WREG  = 3'd5;
    localparam logic [2:0] OP_WPC   = 3'd6;

    localparam logic [3:0] OPC_LOAD   = 4'h1;
    localparam logic [3:0] OPC_LOADI  = 4'h2;
    localparam logic [3:0] OPC_STORE  = 4'h3;
    localparam logic [3:0] OPC_MOVE   = 4'h4;
    localparam logic [3:0] OPC_ADD    = 4'h5;
    localparam logic [3:0] OPC_OR     = 4'h7;
    localparam logic [3:0] OPC_AND    = 4'h8;
    localparam logic [3:0] OPC_XOR    = 4'h9;
    localparam logic [3:0] OPC_ROT    = 4'hA;
    localparam logic [3:0] OPC_BRANCH = 4'hB;
    localparam logic [3:0] OPC_HALT   = 4'hC;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_HALTED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] addr;
        logic [7:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic       clear;
        logic       we;
        logic [3:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [3:0] raddr_a;
        logic [3:0] raddr_b;
    } regs_req_t;

endpackage

### rtl/stc_mem.sv
// Main memory: single-port synchronous RAM with a registered read.
// Per-byte valid flags give all-zero contents after reset. Uses stc_pkg.
module stc_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  stc_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import stc_pkg::*;

    logic [7:0]           mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] valid_reg;
    logic [7:0]           rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.en && req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.en && !req.we)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else if (req.en)
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            else
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'd0;

endmodule

### rtl/stc_regs.sv
// Register file: 16 x 8, two registered read ports, one write port.
// Valid flags clear all entries at once; r0 is kept in a shadow copy. Uses stc_pkg.
module stc_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  stc_pkg::regs_req_t req,
    output logic [7:0]         rdata_a,
    output logic [7:0]         rdata_b,
    output logic [7:0]         r0
);
    import stc_pkg::*;

    logic [7:0]          rf [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [7:0]          qa_reg;
    logic [7:0]          qb_reg;
    logic                va_reg;
    logic                vb_reg;
    logic [7:0]          r0_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            rf[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            qa_reg <= rf[req.raddr_a];
            qb_reg <= rf[req.raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            r0_reg    <= 8'd0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
                r0_reg    <= 8'd0;
            end
            else if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
                if (req.waddr == 4'd0)
                begin
                    r0_reg <= req.wdata;
                end
            end
            if (req.re)
            begin
                va_reg <= valid_reg[req.raddr_a];
                vb_reg <= valid_reg[req.raddr_b];
            end
        end
    end

    assign rdata_a = va_reg ? qa_reg : 8'd0;
    assign rdata_b = vb_reg ? qb_reg : 8'd0;
    assign r0      = r0_reg;

endmodule

### rtl/simple_8bit_teaching_cpu.sv
// Top level of the 8-bit teaching CPU: command sequencer, execute logic, output register.
// Depends on stc_pkg, stc_mem and stc_regs.
//
// A step beat goes through S_ISSUE, S_FETCH1, S_DECODE and S_EXEC: fetch of the high
// byte, fetch of the low byte, operand read, execute. All memory traffic shares the
// single port of main memory. Debug beats (memory and register access, reset, PC
// write) go through S_ISSUE and S_EXEC only. The next command beat is taken in the
// cycle a result is loaded into the output register; a result still waiting downstream
// stalls the execute stage, and with it the command input. Memory reads as zero after
// reset through per-byte valid flags, so no clearing pass is needed.
module simple_8bit_teaching_cpu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  stc_pkg::cmd_beat_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output stc_pkg::rsp_beat_t rsp
);
    import stc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_FETCH1 = 3'd2;
    localparam logic [2:0] S_DECODE = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;

    logic [2:0]  state_reg, state_next;
    cmd_beat_t   cmd_reg;
    logic [7:0]  pc_reg, pc_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] ir_reg, ir_next;
    logic [7:0]  hi_reg;
    logic        out_valid_reg;
    rsp_beat_t   out_reg;

    mem_req_t    mem_req;
    logic [7:0]  mem_rdata;
    regs_req_t   regs_req;
    logic [7:0]  rdata_a, rdata_b, r0;

    logic        exec_go, accept, is_step;
    logic [3:0]  opc, dec_opc;
    logic [7:0]  xy;
    logic [7:0]  alu;
    logic [15:0] rot;
    logic        alu_we;
    rsp_beat_t   result;

    stc_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    stc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (regs_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .r0      (r0)
    );

    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || rsp_ready);
    assign cmd_ready = (state_reg == S_IDLE) || exec_go;
    assign accept    = cmd_valid && cmd_ready;
    assign is_step   = (cmd_reg.op == OP_STEP);

    assign opc     = ir_reg[15:12];
    assign xy      = ir_reg[7:0];
    assign dec_opc = hi_reg[7:4];
    assign rot     = {rdata_a, rdata_a} >> ir_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = S_ISSUE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   state_next = S_IDLE;
                S_ISSUE:  state_next = (cmd_reg.op == OP_STEP) ? S_FETCH1 : S_EXEC;
                S_FETCH1: state_next = S_DECODE;
                S_DECODE: state_next = S_EXEC;
                S_EXEC:   state_next = exec_go ? S_IDLE : S_EXEC;
                default:  state_next = S_IDLE;
            endcase
        end
    end

    // execute stage datapath
    always_comb
    begin
        alu         = 8'd0;
        alu_we      = 1'b0;
        pc_next     = pc_reg;
        status_next = status_reg;
        case (opc)
            OPC_LOAD:   begin alu = mem_rdata;           alu_we = 1'b1; end
            OPC_LOADI:  begin alu = xy;                  alu_we = 1'b1; end
            OPC_STORE:  begin end
            OPC_MOVE:   begin alu = rdata_a;             alu_we = 1'b1; end
            OPC_ADD:    begin alu = 8'(rdata_a + rdata_b); alu_we = 1'b1; end
            OPC_OR:     begin alu = rdata_a | rdata_b;   alu_we = 1'b1; end
            OPC_AND:    begin alu = rdata_a & rdata_b;   alu_we = 1'b1; end
            OPC_XOR:    begin alu = rdata_a ^ rdata_b;   alu_we = 1'b1; end
            OPC_ROT:    begin alu = rot[7:0];            alu_we = 1'b1; end
            OPC_BRANCH:
            begin
                if (rdata_a == r0)
                begin
                    pc_next = xy;
                end
            end
            OPC_HALT:   status_next = ST_HALTED;
            default:    status_next = ST_ERROR;
        endcase
    end

    always_comb
    begin
        result.last_instruction = ir_reg;
        if (is_step)
        begin
            result.read_data  = 8'd0;
            result.pc_now     = pc_next;
            result.run_status = status_next;
        end
        else
        begin
            result.pc_now     = pc_reg;
            result.run_status = status_reg;
            case (cmd_reg.op)
                OP_RMEM: result.read_data = mem_rdata;
                OP_RREG: result.read_data = rdata_a;
                default: result.read_data = 8'd0;
            endcase
        end
    end

    // memory and register port control
    always_comb
    begin
        mem_req  = '0;
        regs_req = '0;
        ir_next  = ir_reg;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_ISSUE:
            begin
                unique case (cmd_reg.op)
                    OP_STEP:
                    begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = pc_reg;
                    end
                    OP_WMEM:
                    begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = cmd_reg.addr;
                        mem_req.wdata = cmd_reg.data;
                    end
                    OP_RMEM:
                    begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = cmd_reg.addr;
                    end
                    OP_RESET: regs_req.clear = 1'b1;
                    OP_RREG:
                    begin
                        regs_req.re      = 1'b1;
                        regs_req.raddr_a = cmd_reg.reg_index;
                    end
                    OP_WREG:
                    begin
                        regs_req.we    = 1'b1;
                        regs_req.waddr = cmd_reg.reg_index;
                        regs_req.wdata = cmd_reg.data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FETCH1:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = 8'(pc_reg + 8'd1);
            end
            S_DECODE:
            begin
                ir_next          = {hi_reg, mem_rdata};
                regs_req.re      = 1'b1;
                regs_req.raddr_b = mem_rdata[3:0];
                case (dec_opc) inside
                    OPC_MOVE, OPC_ADD, OPC_OR, OPC_AND, OPC_XOR:
                        regs_req.raddr_a = mem_rdata[7:4];
                    default:
                        regs_req.raddr_a = hi_reg[3:0];
                endcase
                if (dec_opc == OPC_LOAD)
                begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = mem_rdata;
                end
            end
            S_EXEC:
            begin
                if (exec_go && is_step)
                begin
                    if (opc == OPC_STORE)
                    begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = xy;
                        mem_req.wdata = rdata_a;
                    end
                    regs_req.we    = alu_we;
                    regs_req.waddr = (opc == OPC_MOVE) ? ir_reg[3:0] : ir_reg[11:8];
                    regs_req.wdata = alu;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 8'd0;
            status_reg    <= ST_NORMAL;
            ir_reg        <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ir_reg    <= ir_next;
            if (state_reg == S_ISSUE)
            begin
                if (cmd_reg.op == OP_RESET)
                begin
                    pc_reg     <= 8'd0;
                    status_reg <= ST_NORMAL;
                end
                else if (cmd_reg.op == OP_WPC)
                begin
                    pc_reg <= cmd_reg.data;
                end
            end
            else if (state_reg == S_DECODE)
            begin
                pc_reg <= 8'(pc_reg + 8'd2);
            end
            else if (exec_go && is_step)
            begin
                pc_reg     <= pc_next;
                status_reg <= status_next;
            end
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_FETCH1)
        begin
            hi_reg <= mem_rdata;
        end
        if (exec_go)
        begin
            out_reg <= result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### tb/sv/stc_cpu_checker.sv
// Checker for the 8-bit teaching CPU: watches the command and result channels,
// keeps its own copy of memory, registers, PC, status and last instruction,
// and compares every result beat. Depends on stc_pkg.
module stc_cpu_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  stc_pkg::cmd_beat_t cmd,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  stc_pkg::rsp_beat_t rsp,
    output int                 errors,
    output int                 pending
);
    import stc_pkg::*;

    logic [7:0]  mem_img [MEM_BYTES];
    logic [7:0]  reg_img [NUM_REGS];
    logic [7:0]  pc_img;
    logic [1:0]  status_img;
    logic [15:0] ir_img;
    rsp_beat_t   expected_rsp_q [$];

    function automatic rsp_beat_t execute_beat(input cmd_beat_t c);
        rsp_beat_t   e;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  nxt;
        logic [7:0]  v;
        logic [15:0] vv;
        logic [3:0]  opc;
        logic [3:0]  r;
        logic [3:0]  x;
        logic [3:0]  y;
        e = '0;
        case (c.op)
            OP_STEP:
            begin
                nxt    = pc_img + 8'd1;
                hi     = mem_img[pc_img];
                lo     = mem_img[nxt];
                ir_img = {hi, lo};
                pc_img = pc_img + 8'd2;
                opc    = hi[7:4];
                r      = hi[3:0];
                x      = lo[7:4];
                y      = lo[3:0];
                case (opc)
                    OPC_LOAD:   reg_img[r] = mem_img[lo];
                    OPC_LOADI:  reg_img[r] = lo;
                    OPC_STORE:  mem_img[lo] = reg_img[r];
                    OPC_MOVE:   reg_img[y] = reg_img[x];
                    OPC_ADD:    reg_img[r] = reg_img[x] + reg_img[y];
                    OPC_OR:     reg_img[r] = reg_img[x] | reg_img[y];
                    OPC_AND:    reg_img[r] = reg_img[x] & reg_img[y];
                    OPC_XOR:    reg_img[r] = reg_img[x] ^ reg_img[y];
                    OPC_ROT:
                    begin
                        v          = reg_img[r];
                        vv         = {v, v} >> y[2:0];
                        reg_img[r] = vv[7:0];
                    end
                    OPC_BRANCH:
                    begin
                        if (reg_img[r] == reg_img[0])
                            pc_img = lo;
                    end
                    OPC_HALT:   status_img = ST_HALTED;
                    default:    status_img = ST_ERROR;
                endcase
            end
            OP_WMEM:  mem_img[c.addr] = c.data;
            OP_RMEM:  e.read_data = mem_img[c.addr];
            OP_RESET:
            begin
                for (int i = 0; i < NUM_REGS; i++)
                    reg_img[4'(i)] = 8'h00;
                pc_img     = 8'h00;
                status_img = ST_NORMAL;
            end
            OP_RREG:  e.read_data = reg_img[c.reg_index];
            OP_WREG:  reg_img[c.reg_index] = c.data;
            OP_WPC:   pc_img = c.data;
            default:  ;
        endcase
        e.pc_now           = pc_img;
        e.run_status       = status_img;
        e.last_instruction = ir_img;
        return e;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_BYTES; i++)
                mem_img[8'(i)] = 8'h00;
            for (int i = 0; i < NUM_REGS; i++)
                reg_img[4'(i)] = 8'h00;
            pc_img     = 8'h00;
            status_img = ST_NORMAL;
            ir_img     = 16'h0000;
            expected_rsp_q.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                    note_mismatch("result beat with nothing pending", 32'h0, 32'(rsp));
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.read_data !== want.read_data)
                        note_mismatch("read_data", 32'(want.read_data), 32'(rsp.read_data));
                    if (rsp.pc_now !== want.pc_now)
                        note_mismatch("pc_now", 32'(want.pc_now), 32'(rsp.pc_now));
                    if (rsp.run_status !== want.run_status)
                        note_mismatch("run_status", 32'(want.run_status),
                                      32'(rsp.run_status));
                    if (rsp.last_instruction !== want.last_instruction)
                        note_mismatch("last_instruction", 32'(want.last_instruction),
                                      32'(rsp.last_instruction));
                end
            end
            if (cmd_valid && cmd_ready)
                expected_rsp_q.push_back(execute_beat(cmd));
            pending = expected_rsp_q.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the 8-bit teaching CPU: clock, reset, command stimulus,
// random result back-pressure and the verdict. Depends on stc_pkg,
// simple_8bit_teaching_cpu and stc_cpu_checker.
module tb_top;
    import stc_pkg::*;

    localparam int         ITEMS       = 550;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [2:0] OP_SPARE    = 3'd7;
    localparam logic [3:0] OPC_UNDEF_0 = 4'h0;
    localparam logic [3:0] OPC_FADD    = 4'h6;
    localparam logic [3:0] OPC_UNDEF_D = 4'hD;
    localparam logic [3:0] OPC_UNDEF_E = 4'hE;
    localparam logic [3:0] OPC_UNDEF_F = 4'hF;

    logic      clk       = 1'b0;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    cmd_beat_t cmd;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_beat_t rsp;

    int errors;
    int pending;
    int snd_idle   = 23;
    int rcv_idle   = 52;
    int beats_sent = 0;
    int cycles     = 0;
    int phase      = 0;

    simple_8bit_teaching_cpu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    stc_cpu_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= rcv_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic cmd_beat_t beat_of(input logic [2:0] op, input logic [7:0] addr,
                                          input logic [3:0] ri, input logic [7:0] data);
        cmd_beat_t c;
        c.op        = op;
        c.addr      = addr;
        c.reg_index = ri;
        c.data      = data;
        return c;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input cmd_beat_t c);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic send_random_beat();
        send_beat(beat_of(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
    endtask

    task automatic run_program();
        logic [7:0] base;
        logic [7:0] a;
        logic [7:0] lo;
        logic [3:0] opc;
        logic [3:0] r;
        int         len;
        int         steps;
        base = 8'($urandom_range(0, 255));
        len  = $urandom_range(2, 8);
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3))
                send_random_beat();
        repeat ($urandom_range(0, 3))
            send_beat(beat_of(OP_WREG, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                              8'($urandom_range(0, 255))));
        for (int i = 0; i < len; i++)
        begin
            r  = 4'($urandom_range(0, 15));
            lo = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 8)
            begin
                case ($urandom_range(0, 4))
                    0:       opc = OPC_UNDEF_0;
                    1:       opc = OPC_FADD;
                    2:       opc = OPC_UNDEF_D;
                    3:       opc = OPC_UNDEF_E;
                    default: opc = OPC_UNDEF_F;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 10))
                    0:       opc = OPC_LOAD;
                    1:       opc = OPC_LOADI;
                    2:       opc = OPC_STORE;
                    3:       opc = OPC_MOVE;
                    4:       opc = OPC_ADD;
                    5:       opc = OPC_OR;
                    6:       opc = OPC_AND;
                    7:       opc = OPC_XOR;
                    8:       opc = OPC_ROT;
                    9:       opc = OPC_BRANCH;
                    default: opc = OPC_HALT;
                endcase
            end
            if (opc == OPC_BRANCH && $urandom_range(0, 1) == 1)
            begin
                r  = 4'h0;
                lo = base + 8'(2 * $urandom_range(0, len - 1));
            end
            a = base + 8'(2 * i);
            send_beat(beat_of(OP_WMEM, a, 4'($urandom_range(0, 15)), {opc, r}));
            a = a + 8'd1;
            send_beat(beat_of(OP_WMEM, a, 4'($urandom_range(0, 15)), lo));
        end
        send_beat(beat_of(OP_WPC, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                          base));
        steps = len + $urandom_range(0, 4);
        repeat (steps)
        begin
            send_beat(beat_of(OP_STEP, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                              8'($urandom_range(0, 255))));
            if ($urandom_range(0, 99) < 20)
                send_beat(beat_of($urandom_range(0, 1) ? OP_RREG : OP_RMEM,
                                  8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                  8'($urandom_range(0, 255))));
        end
        if ($urandom_range(0, 99) < 5)
            send_beat(beat_of(OP_RESET, 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_beat(beat_of(OP_RMEM,  8'h00, 4'h0, 8'h00));
        send_beat(beat_of(OP_STEP,  8'h00, 4'h0, 8'h00));
        send_beat(beat_of(OP_RESET, 8'h00, 4'h0, 8'h00));
        send_beat(beat_of(OP_WREG,  8'h00, 4'hF, 8'h81));
        send_beat(beat_of(OP_WREG,  8'h00, 4'h0, 8'hFF));
        send_beat(beat_of(OP_RREG,  8'h00, 4'hF, 8'h00));
        // rotate r15 by 7, fetched across the top of memory
        send_beat(beat_of(OP_WMEM,  8'hFF, 4'h0, {OPC_ROT, 4'hF}));
        send_beat(beat_of(OP_WMEM,  8'h00, 4'h0, 8'h07));
        send_beat(beat_of(OP_WPC,   8'h00, 4'h0, 8'hFF));
        send_beat(beat_of(OP_STEP,  8'h00, 4'h0, 8'h00));
        send_beat(beat_of(OP_RMEM,  8'hFF, 4'h0, 8'h00));
        send_beat(beat_of(OP_WMEM,  8'h01, 4'h0, {OPC_FADD, 4'h1}));
        send_beat(beat_of(OP_WMEM,  8'h02, 4'h0, 8'h23));
        send_beat(beat_of(OP_STEP,  8'h00, 4'h0, 8'h00));
        // load immediate while in error state
        send_beat(beat_of(OP_WMEM,  8'h03, 4'h0, {OPC_LOADI, 4'hE}));
        send_beat(beat_of(OP_WMEM,  8'h04, 4'h0, 8'hFF));
        send_beat(beat_of(OP_STEP,  8'h00, 4'h0, 8'h00));
        send_beat(beat_of(OP_WMEM,  8'h05, 4'h0, {OPC_HALT, 4'h0}));
        send_beat(beat_of(OP_WMEM,  8'h06, 4'h0, 8'h00));
        send_beat(beat_of(OP_STEP,  8'h00, 4'h0, 8'h00));
        send_beat(beat_of(OP_RESET, 8'h00, 4'h0, 8'h00));
        send_beat(beat_of(OP_SPARE, 8'hFF, 4'hF, 8'hFF));
        send_beat(beat_of(OP_RREG,  8'h00, 4'hE, 8'h00));
        send_beat(beat_of(OP_STEP,  8'hFF, 4'hF, 8'hFF));

        while (beats_sent < ITEMS)
        begin
            if (phase == 0 && beats_sent >= ITEMS / 3)
            begin
                drain_results();
                snd_idle = 52;
                rcv_idle = 23;
                phase    = 1;
            end
            else if (phase == 1 && beats_sent >= 2 * ITEMS / 3)
            begin
                drain_results();
                snd_idle = 0;
                rcv_idle = 0;
                phase    = 2;
            end
            run_program();
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/stc_pkg.sv
rtl/stc_mem.sv
rtl/stc_regs.sv
rtl/simple_8bit_teaching_cpu.sv
tb/sv/stc_cpu_checker.sv
tb/sv/tb_top.sv
